/* design/ged_pkg.sv */
// Shared constants and types of the guarded escape sequence detector.
`timescale 1ns / 1ps
`default_nettype none

package ged_pkg;

   // Number of channels, each with its own detector.
   localparam int CHANNELS = 4;

   // Field widths.
   localparam int MODE_W    = 2;
   localparam int CHAN_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int STATE_W   = 3;
   localparam int COUNT_W   = 4;
   localparam int INDEX_W   = 2;
   localparam int MASK_W    = 4;
   localparam int CSR_IDX_W = 3;

   // Padded stream widths.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Item kinds carried in the request tuser.
   localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACK  = 2'd2;

   // Detector state codes.
   localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
   localparam logic [STATE_W-1:0] ST_PAUSE    = 3'd1;
   localparam logic [STATE_W-1:0] ST_MATCHING = 3'd2;
   localparam logic [STATE_W-1:0] ST_MATCHED  = 3'd3;
   localparam logic [STATE_W-1:0] ST_ESCAPE   = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GUARD_TICKS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_FIRST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_SECOND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_THIRD   = 3'd4;

   // Register reset values.
   localparam logic [MASK_W-1:0]  RST_CHANNEL_ENABLE = 4'd0;
   localparam logic [COUNT_W-1:0] RST_GUARD_TICKS    = 4'd10;
   localparam logic [BYTE_W-1:0]  RST_ESCAPE_FIRST   = 8'd97;
   localparam logic [BYTE_W-1:0]  RST_ESCAPE_SECOND  = 8'd98;
   localparam logic [BYTE_W-1:0]  RST_ESCAPE_THIRD   = 8'd99;

   // Per-channel detector context.
   typedef struct packed {
      logic [COUNT_W-1:0] silence;
      logic [STATE_W-1:0] state;
      logic [INDEX_W-1:0] index;
   } chan_type;

endpackage

`default_nettype wire

/* design/guarded_escape_sequence_detector_unit.sv */
// Top level of the guarded escape sequence detector.
`timescale 1ns / 1ps
`default_nettype none

// Guarded escape sequence detector, one detector per channel.
//
// The request stream carries one item per transfer: a received byte, a
// tick for all channels, or an acknowledge. The kind travels in tuser and
// the channel number and byte in tdata. Every request gives exactly one
// response transfer holding the addressed channel's state after the item
// and the mask of channels that have detected an escape.
//
// All per-channel contexts live in flip-flops and are updated together in
// the cycle of the request transfer, so the response appears in the cycle
// after acceptance and, unless the receiver stalls, one item per cycle is
// sustained, set by the single response register.
//
// When the receiver stalls, the response is held and req_tready falls
// only while that held response is still waiting; once it is taken the
// next request may enter in the same cycle.
//
// Reset (synchronous, active high) returns every channel to idle with
// cleared counters and loads the register defaults. The configuration
// channel always accepts and must only be written while the block is idle.
module guarded_escape_sequence_detector_unit (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   // Request stream.
   input  wire  logic                              req_tvalid,
   output       logic                              req_tready,
   // [1:0] channel, [9:2] data_byte, [15:10] zero
   input  wire  logic [ged_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] mode
   input  wire  logic [ged_pkg::MODE_W-1:0]        req_tuser,
   // Response stream.
   output       logic                              rsp_tvalid,
   input  wire  logic                              rsp_tready,
   // [2:0] channel_state, [6:3] escape_mask, [7] zero
   output       logic [ged_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write channel.
   input  wire  logic                              csr_valid,
   output       logic                              csr_ready,
   input  wire  logic [ged_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  logic [ged_pkg::BYTE_W-1:0]        csr_data
);
   import ged_pkg::*;

   // Configuration registers.
   logic [MASK_W-1:0]  channel_enable_ff;
   logic [COUNT_W-1:0] guard_ticks_ff;
   logic [BYTE_W-1:0]  escape_first_ff;
   logic [BYTE_W-1:0]  escape_second_ff;
   logic [BYTE_W-1:0]  escape_third_ff;

   // Channel contexts and their next values.
   chan_type chan_ff [CHANNELS];
   chan_type chan_in [CHANNELS];

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [STATE_W-1:0] rsp_state_ff;
   logic [STATE_W-1:0] rsp_state_in;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic [MASK_W-1:0]  rsp_mask_in;

   // Decoded request fields.
   logic [MODE_W-1:0]  req_mode;
   logic [CHAN_W-1:0]  req_channel;
   logic [BYTE_W-1:0]  req_byte;
   logic               req_accept;
   logic               chan_valid;

   assign req_mode    = req_tuser;
   assign req_channel = req_tdata[CHAN_W-1:0];
   assign req_byte    = req_tdata[CHAN_W+BYTE_W-1:CHAN_W];

   // The response register is free when empty or being emptied this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // A channel number past the last detector addresses nothing.
   assign chan_valid = ({1'b0, req_channel} < (CHAN_W + 1)'(CHANNELS));

   // Next context of every channel for the current request.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic addressed;
         logic enabled;
         logic hit;
         addressed  = chan_valid && (req_channel == CHAN_W'(c));
         enabled    = channel_enable_ff[c];
         chan_in[c] = chan_ff[c];
         hit        = 1'b0;
         if (req_accept) begin
            if (req_mode == MODE_BYTE && addressed && enabled) begin
               // A byte always breaks the silence.
               chan_in[c].silence = '0;
               unique case (chan_ff[c].index)
                  2'd0:    hit = (req_byte == escape_first_ff);
                  2'd1:    hit = (req_byte == escape_second_ff);
                  2'd2:    hit = (req_byte == escape_third_ff);
                  default: hit = 1'b0;
               endcase
               if (chan_ff[c].state == ST_PAUSE && req_byte == escape_first_ff) begin
                  chan_in[c].index = INDEX_W'(1);
                  chan_in[c].state = ST_MATCHING;
               end else if (chan_ff[c].state == ST_MATCHING && hit) begin
                  if (chan_ff[c].index == INDEX_W'(2)) begin
                     chan_in[c].index = '0;
                     chan_in[c].state = ST_MATCHED;
                  end else begin
                     chan_in[c].index = chan_ff[c].index + INDEX_W'(1);
                  end
               end else begin
                  // Anything that does not continue the sequence starts over.
                  chan_in[c].index = '0;
                  chan_in[c].state = ST_IDLE;
               end
            end else if (req_mode == MODE_TICK && enabled) begin
               // The counter saturates at the guard time; from then on each
               // tick may take a pause transition.
               if (chan_ff[c].silence >= guard_ticks_ff) begin
                  if (chan_ff[c].state == ST_IDLE) begin
                     chan_in[c].state = ST_PAUSE;
                  end else if (chan_ff[c].state == ST_MATCHED) begin
                     chan_in[c].state = ST_ESCAPE;
                  end
               end else begin
                  chan_in[c].silence = chan_ff[c].silence + COUNT_W'(1);
               end
            end else if (req_mode == MODE_ACK && addressed) begin
               // Acknowledge works whether or not the channel is enabled.
               if (chan_ff[c].state == ST_ESCAPE) begin
                  chan_in[c].state = ST_IDLE;
               end
            end
         end
      end
   end

   // Response contents, taken from the updated contexts.
   always_comb begin
      rsp_state_in = ST_IDLE;
      rsp_mask_in  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (chan_valid && req_channel == CHAN_W'(c)) begin
            rsp_state_in = chan_in[c].state;
         end
         rsp_mask_in[c] = (chan_in[c].state == ST_ESCAPE);
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c] <= '{silence: '0, state: ST_IDLE, index: '0};
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c] <= chan_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_state_ff <= rsp_state_in;
         rsp_mask_ff  <= rsp_mask_in;
      end
   end

   // Configuration writes; indexes past the last register are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_enable_ff <= RST_CHANNEL_ENABLE;
         guard_ticks_ff    <= RST_GUARD_TICKS;
         escape_first_ff   <= RST_ESCAPE_FIRST;
         escape_second_ff  <= RST_ESCAPE_SECOND;
         escape_third_ff   <= RST_ESCAPE_THIRD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CHANNEL_ENABLE: channel_enable_ff <= csr_data[MASK_W-1:0];
            REG_GUARD_TICKS:    guard_ticks_ff    <= csr_data[COUNT_W-1:0];
            REG_ESCAPE_FIRST:   escape_first_ff   <= csr_data;
            REG_ESCAPE_SECOND:  escape_second_ff  <= csr_data;
            REG_ESCAPE_THIRD:   escape_third_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_mask_ff, rsp_state_ff};

endmodule

`default_nettype wire

/* design/ged_checker.sv */
// Port-level checks of the guarded escape sequence detector and their bind.
`timescale 1ns / 1ps
`default_nettype none

module ged_checker (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              req_tvalid,
   input  wire  logic                              req_tready,
   input  wire  logic                              rsp_tvalid,
   input  wire  logic                              rsp_tready,
   input  wire  logic [ged_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ged_pkg::*;

   // A stalled response holds its contents.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled response changed or vanished");

   // Every accepted request is answered in the following cycle.
   property p_latency;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready |=> rsp_tvalid;
   endproperty
   a_latency: assert property (p_latency)
      else $error("response missing one cycle after request transfer");

   // An empty response register never holds back a request.
   property p_ready_when_empty;
      @(posedge clock) disable iff (reset)
         !rsp_tvalid |-> req_tready;
   endproperty
   a_ready_when_empty: assert property (p_ready_when_empty)
      else $error("request stalled with no response pending");

   // A channel reported in escape detected must show in the mask.
   property p_escape_in_mask;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tdata[STATE_W-1:0] == ST_ESCAPE
            |-> rsp_tdata[STATE_W+MASK_W-1:STATE_W] != '0;
   endproperty
   a_escape_in_mask: assert property (p_escape_in_mask)
      else $error("escape state reported with empty mask");

   // No response is pending straight after reset.
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("response valid after reset");

endmodule

bind guarded_escape_sequence_detector_unit ged_checker u_ged_checker (.*);

`default_nettype wire
